/* rtl/core/weighted_sum_neuron_assert.svh */
// Assertion macros shared by the neuron RTL
`ifndef WEIGHTED_SUM_NEURON_ASSERT_SVH
`define WEIGHTED_SUM_NEURON_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define WSN_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication into the next cycle
`define WSN_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* rtl/core/wsn_pkg.sv */
// ----------------------------------------------------------------------------
// wsn_pkg
// Types and constants for the weighted sum neuron.
// ----------------------------------------------------------------------------
package wsn_pkg;
   localparam int PINS = 64;
   localparam int IDX_W = $clog2(PINS);
   localparam int CNT_W = $clog2(PINS + 1);
   localparam int SUM_W = 38;

   localparam logic [1:0] MODE_WEIGHT = 2'd0;
   localparam logic [1:0] MODE_SAMPLE = 2'd1;
   localparam logic [1:0] MODE_RUN    = 2'd2;

   localparam logic [1:0] FN_STEP    = 2'd0;
   localparam logic [1:0] FN_SIGN    = 2'd1;
   localparam logic [1:0] FN_SIGMOID = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_FN  = 2'd1;
   localparam logic [1:0] ST_NO_PINS = 2'd2;

   localparam logic [15:0] ONE_Q14 = 16'sd16384;
   localparam logic [15:0] MONE_Q14 = 16'hC000;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [31:0] Q30_EXP_M1 = 32'd395007542;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  pin_index;
      logic [15:0] value;
      logic [1:0]  function_type;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_value;
      logic [37:0] dot_sum;
      logic [37:0] base_value;
   } rsp_type;
endpackage

/* rtl/core/wsn_if.sv */
// ----------------------------------------------------------------------------
// wsn_req_if / wsn_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface wsn_req_if;
   import wsn_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface wsn_rsp_if;
   import wsn_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/wsn_ram.sv */
// ----------------------------------------------------------------------------
// wsn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

/* rtl/core/wsn_alu.sv */
// ----------------------------------------------------------------------------
// wsn_alu
// Shared multiply unit: one registered 32x32 unsigned product a cycle.
// ----------------------------------------------------------------------------
module wsn_alu (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);
   logic [63:0] prod_ff;
   always_ff @(posedge clock) begin
      prod_ff <= {32'd0, op_a} * {32'd0, op_b};
   end
   assign prod = prod_ff;
endmodule

/* rtl/core/weighted_sum_neuron.sv */
// ----------------------------------------------------------------------------
// weighted_sum_neuron
// Perceptron neuron: weight and sample tables, dot product, activation.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | mode, pin_index, value, function_type
//  rsp     | out | valid / ready   | status, out_value, dot_sum, base_value
//
// A run walks the tables through the shared multiplier, divides by the count
// with a 38-step restoring divider, then for sigmoid runs 12 Taylor steps (a
// multiply and a 32-step divide by the term index each), up to ten e^-1 steps
// and a rounding divider.
// Synchronous reset clears state, pin count and valid flag; no clearing pass.
// A finished result waits in the output register until taken; requests are
// still accepted meanwhile, and a later run holds its result until it is free.
module weighted_sum_neuron (
   input  logic clock,
   input  logic reset,
   wsn_req_if.sink   req,
   wsn_rsp_if.source rsp
);
   import wsn_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_MAC  = 10'b0000000010,
      S_DIV  = 10'b0000000100,
      S_TAY  = 10'b0000001000,
      S_EXP  = 10'b0000010000,
      S_SDIV = 10'b0000100000,
      S_OUT  = 10'b0001000000,
      S_FIN  = 10'b0010000000,
      S_WAIT = 10'b0100000000,
      S_ACT  = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [1:0]         ph_ff, ph_in;
   logic [1:0]         fn_ff, fn_in;
   logic [37:0]        sum_ff, sum_in;
   logic [37:0]        base_ff, base_in;
   logic [45:0]        quo_ff, quo_in;
   logic [46:0]        rem_ff, rem_in;
   logic [5:0]         step_ff, step_in;
   logic [31:0]        term_ff, term_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        rq_ff, rq_in;
   logic [3:0]         n_ff, n_in;
   logic [45:0]        num_ff, num_in;
   logic [31:0]        den_ff, den_in;
   rsp_type            out_ff, out_in;
   logic               vld_ff, vld_in;

   logic               take;
   logic               wr_w, wr_s;
   logic [15:0]        w_rd, s_rd;
   logic [IDX_W-1:0]   rd_addr;
   logic [31:0]        op_a, op_b;
   logic [63:0]        prod;
   logic               neg;
   logic [47:0]        rtrial;
   logic [38:0]        dtrial;
   logic [6:0]         ttrial;
   logic [37:0]        smag;
   logic [31:0]        tq;
   logic [15:0]        sg;

   assign req.ready = state_ff == S_IDLE;
   assign take = req.valid && req.ready;
   assign wr_w = take && req.data.mode == MODE_WEIGHT;
   assign wr_s = take && req.data.mode == MODE_SAMPLE;
   assign rd_addr = ptr_ff[IDX_W-1:0];

   wsn_ram #(.WIDTH(16), .DEPTH(PINS)) u_wram (
      .clock(clock), .wr_en(wr_w), .wr_addr(req.data.pin_index[IDX_W-1:0]),
      .wr_data(req.data.value), .rd_addr(rd_addr), .rd_data(w_rd));
   wsn_ram #(.WIDTH(16), .DEPTH(PINS)) u_sram (
      .clock(clock), .wr_en(wr_s), .wr_addr(req.data.pin_index[IDX_W-1:0]),
      .wr_data(req.data.value), .rd_addr(rd_addr), .rd_data(s_rd));

   // operand selection for the shared multiplier
   always_comb begin
      op_a = 32'd0;
      op_b = 32'd0;
      if (state_ff == S_MAC) begin
         op_a = {{16{w_rd[15]}}, w_rd};
         op_b = {{16{s_rd[15]}}, s_rd};
      end else if (state_ff == S_TAY) begin
         op_a = term_ff;
         op_b = rq_ff;
      end else if (state_ff == S_EXP) begin
         op_a = acc_ff;
         op_b = Q30_EXP_M1;
      end
   end

   wsn_alu u_alu (.clock(clock), .op_a(op_a), .op_b(op_b), .prod(prod));

   assign neg = sum_ff[37];
   assign smag = sum_ff[37] ? (38'd0 - sum_ff) : sum_ff;
   assign tq = prod[61:30];
   assign dtrial = {rem_ff[37:0], quo_ff[37]} - {32'd0, count_ff};
   assign rtrial = {rem_ff[46:0], num_ff[45]} - {16'd0, den_ff};
   // trial subtract of the term index; remainder stays below 12
   assign ttrial = {1'b0, rem_ff[4:0], quo_ff[31]} - {1'b0, step_ff};
   assign sg = quo_ff[15:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      ph_in = ph_ff;
      fn_in = fn_ff;
      sum_in = sum_ff;
      base_in = base_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      term_in = term_ff;
      acc_in = acc_ff;
      rq_in = rq_ff;
      n_in = n_ff;
      num_in = num_ff;
      den_in = den_ff;
      out_in = out_ff;
      vld_in = vld_ff;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (wr_s) count_in = {1'b0, req.data.pin_index} + 7'd1;
               if (req.data.mode == MODE_RUN) begin
                  fn_in = req.data.function_type;
                  sum_in = '0;
                  base_in = '0;
                  ptr_in = '0;
                  ph_in = 2'd0;
                  if (count_ff == '0) begin
                     state_in = S_OUT;
                  end else begin
                     state_in = S_MAC;
                  end
               end
            end
         end
         // read, multiply, accumulate: address at ph0, product at ph2
         S_MAC: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) ph_in = 2'd2;
            if (ph_ff == 2'd2) begin
               sum_in = sum_ff + {{6{prod[31]}}, prod[31:0]};
               ph_in = 2'd0;
               if (ptr_ff + 7'd1 == count_ff) begin
                  state_in = S_DIV;
                  quo_in = {8'd0, (sum_in[37] ? 38'd0 - sum_in : sum_in)};
                  rem_in = '0;
                  step_in = 6'd0;
               end else begin
                  ptr_in = ptr_ff + 7'd1;
               end
            end
         end
         // restoring divide of |sum| by the count
         S_DIV: begin
            if (!dtrial[38]) begin
               rem_in = {9'd0, dtrial[37:0]};
               quo_in = {quo_ff[44:0], 1'b1};
            end else begin
               rem_in = {9'd0, rem_ff[36:0], quo_ff[37]};
               quo_in = {quo_ff[44:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd37) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            base_in = neg ? (38'd0 - quo_ff[37:0]) : quo_ff[37:0];
            state_in = S_OUT;
            if (fn_ff == FN_SIGMOID) begin
               rq_in = {2'd0, smag[15:0], 14'd0};
               n_in = smag[19:16];
               term_in = Q30_ONE;
               acc_in = Q30_ONE;
               step_in = 6'd1;
               ph_in = 2'd0;
               state_in = S_TAY;
               if (smag >= 38'd720896) begin
                  acc_in = 32'd0;
                  state_in = S_SDIV;
                  step_in = 6'd0;
               end
            end
         end
         // Taylor series on the fraction: term = (term*r >> 30) / k,
         // the divide by k done one quotient bit a cycle
         S_TAY: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               quo_in = {14'd0, tq};
               rem_in = '0;
               ptr_in = '0;
               ph_in = 2'd2;
            end else begin
               if (!ttrial[6]) begin
                  rem_in = {41'd0, ttrial[5:0]};
                  quo_in = {quo_ff[44:0], 1'b1};
               end else begin
                  rem_in = {41'd0, rem_ff[4:0], quo_ff[31]};
                  quo_in = {quo_ff[44:0], 1'b0};
               end
               ptr_in = ptr_ff + 7'd1;
               if (ptr_ff == 7'd31) begin
                  term_in = quo_in[31:0];
                  acc_in = step_ff[0] ? acc_ff - term_in : acc_ff + term_in;
                  ph_in = 2'd0;
                  step_in = step_ff + 6'd1;
                  if (step_ff == 6'd12) begin
                     state_in = n_ff == 4'd0 ? S_SDIV : S_EXP;
                     step_in = 6'd0;
                  end
               end
            end
         end
         // integer part: repeated multiply by e^-1
         S_EXP: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) begin
               acc_in = tq;
               ph_in = 2'd0;
               n_in = n_ff - 4'd1;
               if (n_ff == 4'd1) state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            if (step_ff == 6'd0) begin
               den_in = Q30_ONE + acc_ff;
               num_in = neg ? ({32'd0, 14'd0} | ({14'd0, acc_ff} << 14))
                            : (46'd1 << 44);
               step_in = 6'd1;
               ph_in = 2'd0;
            end else if (ph_ff == 2'd0) begin
               num_in = num_ff + {15'd0, den_ff[31:1]};
               quo_in = '0;
               rem_in = '0;
               ph_in = 2'd1;
            end else begin
               if (!rtrial[47]) begin
                  rem_in = rtrial[46:0];
                  quo_in = {quo_ff[44:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[45:0], num_ff[45]};
                  quo_in = {quo_ff[44:0], 1'b0};
               end
               num_in = {num_ff[44:0], 1'b0};
               step_in = step_ff + 6'd1;
               if (step_ff == 6'd46) state_in = S_FIN;
            end
         end
         // load the result once the output register is free
         S_FIN: begin
            if (!vld_ff || rsp.ready) begin
               out_in.out_value = ($signed(sum_ff) < $signed(base_ff)) ? 16'd0 - sg : sg;
               out_in.status = ST_OK;
               out_in.dot_sum = sum_ff;
               out_in.base_value = base_ff;
               state_in = S_WAIT;
            end
         end
         S_OUT: begin
            if (!vld_ff || rsp.ready) begin
               out_in.status = ST_OK;
               out_in.dot_sum = sum_ff;
               out_in.base_value = base_ff;
               case (fn_ff)
                  FN_STEP: out_in.out_value =
                     ($signed(sum_ff) > $signed(base_ff)) ? 16'd0 : ONE_Q14;
                  FN_SIGN: out_in.out_value =
                     ($signed(sum_ff) >= $signed(base_ff)) ? ONE_Q14 : MONE_Q14;
                  default: begin
                     out_in.status = ST_BAD_FN;
                     out_in.out_value = 16'd0;
                  end
               endcase
               // empty table wins over a bad function type
               if (count_ff == '0) out_in = '{ST_NO_PINS, 16'd0, 38'd0, 38'd0};
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!vld_ff || rsp.ready) begin
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vld_ff <= vld_in;
      end
      ptr_ff <= ptr_in;
      ph_ff <= ph_in;
      fn_ff <= fn_in;
      sum_ff <= sum_in;
      base_ff <= base_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      term_ff <= term_in;
      acc_ff <= acc_in;
      rq_ff <= rq_in;
      n_ff <= n_in;
      num_ff <= num_in;
      den_ff <= den_in;
      out_ff <= out_in;
   end

   assign rsp.valid = vld_ff;
   assign rsp.data = out_ff;

`include "weighted_sum_neuron_assert.svh"
   `WSN_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req.ready)
   `WSN_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(PINS))
   `WSN_ASSERT_NEXT(a_hold, clock, reset, vld_ff && !rsp.ready, vld_ff && $stable(out_ff))
endmodule
